FILE: rtl/ppi_pkg.sv
// shared types, constants and tables of the planar pose integrator
package ppi_pkg;

  // cordic iteration count and counter width
  localparam int CORDIC_STEPS = 16;
  localparam int ITER_W       = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
  localparam int ATAN_IDX_W   = 5;

  // fixed-point constants
  localparam logic signed [31:0] CORDIC_GAIN      = 32'sd652032874;   // 0.6072529350 q2.30
  localparam logic signed [31:0] FOUR_OVER_PI_Q30 = 32'sd1367130551;
  localparam logic        [7:0]  BROADCAST_ID     = 8'd99;
  localparam logic signed [31:0] LAND_Z           = 32'sd3277;        // 0.05 m

  // widths of held state
  localparam int VEL_W  = 18;
  localparam int RATE_W = 16;
  localparam logic signed [VEL_W-1:0] VEL_MAX = 18'sd131071;
  localparam logic signed [VEL_W-1:0] VEL_MIN = -18'sd131072;

  // reset values of registers and pose
  localparam logic        [7:0]  OWN_ID_RST     = 8'd0;
  localparam logic signed [31:0] START_X_RST    = 32'sd0;
  localparam logic signed [31:0] START_Y_RST    = 32'sd0;
  localparam logic signed [31:0] START_Z_RST    = 32'sd655;
  localparam logic        [31:0] START_HEAD_RST = 32'd0;
  localparam logic signed [31:0] FLY_HEIGHT_RST = 32'sd6554;
  localparam logic        [15:0] STEP_TIME_RST  = 16'd655;

  // input operation codes
  typedef enum logic [1:0] {
    OP_MODE = 2'd0,
    OP_VEL  = 2'd1,
    OP_TICK = 2'd2
  } op_t;

  // control modes
  typedef enum logic [2:0] {
    MODE_INIT      = 3'd0,
    MODE_HOLD      = 3'd1,
    MODE_POS       = 3'd2,
    MODE_VEL_BODY  = 3'd3,
    MODE_VEL_WORLD = 3'd4,
    MODE_TAKEOFF   = 3'd5,
    MODE_LAND      = 3'd6,
    MODE_OTHER     = 3'd7
  } mode_t;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_OWN_ID     = 3'd0,
    CFG_START_X    = 3'd1,
    CFG_START_Y    = 3'd2,
    CFG_START_Z    = 3'd3,
    CFG_START_HEAD = 3'd4,
    CFG_FLY_HEIGHT = 3'd5,
    CFG_STEP_TIME  = 3'd6
  } cfg_idx_t;

  // multiplier operand pairs
  typedef enum logic [2:0] {
    MUL_FC,   // forward * cos
    MUL_LS,   // left * sin
    MUL_FS,   // forward * sin
    MUL_LC,   // left * cos
    MUL_EDT,  // east velocity * dt
    MUL_NDT,  // north velocity * dt
    MUL_RDT,  // turn rate * dt
    MUL_PK    // previous product * 4/pi
  } mul_sel_t;

  typedef enum logic [1:0] {
    ACC_NONE,
    ACC_LOAD,
    ACC_ADD,
    ACC_SUB
  } acc_op_t;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_EAST,
    WR_NORTH,
    WR_X,
    WR_Y,
    WR_HEAD
  } wr_t;

  typedef enum logic [1:0] {
    Z_KEEP,
    Z_FLY,
    Z_LAND
  } z_sel_t;

  // controller to datapath
  typedef struct packed {
    logic     capture;
    logic     set_mode;
    logic     cordic_start;
    logic     ang_double;
    mul_sel_t mul_sel;
    acc_op_t  acc_op;
    wr_t      wr;
    z_sel_t   z_sel;
    logic     out_load;
    logic     out_null;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    op_t   op;
    logic  mode_hit;
    mode_t ctrl_mode;
    logic  cordic_busy;
    logic  out_free;
  } sts_t;

  // arctangent of 2^-i as a binary angle, unit 2pi/2^32
  function automatic logic signed [31:0] atan_at(input logic [ATAN_IDX_W-1:0] i);
    logic signed [31:0] v;
    case (i)
      5'd0:    v = 32'sh20000000;
      5'd1:    v = 32'sh12E4051E;
      5'd2:    v = 32'sh09FB385B;
      5'd3:    v = 32'sh051111D4;
      5'd4:    v = 32'sh028B0D43;
      5'd5:    v = 32'sh0145D7E1;
      5'd6:    v = 32'sh00A2F61E;
      5'd7:    v = 32'sh00517C55;
      5'd8:    v = 32'sh0028BE53;
      5'd9:    v = 32'sh00145F2F;
      5'd10:   v = 32'sh000A2F98;
      5'd11:   v = 32'sh000517CC;
      5'd12:   v = 32'sh00028BE6;
      5'd13:   v = 32'sh000145F3;
      5'd14:   v = 32'sh0000A2FA;
      5'd15:   v = 32'sh0000517D;
      5'd16:   v = 32'sh000028BE;
      5'd17:   v = 32'sh0000145F;
      5'd18:   v = 32'sh00000A30;
      5'd19:   v = 32'sh00000518;
      5'd20:   v = 32'sh0000028C;
      5'd21:   v = 32'sh00000146;
      5'd22:   v = 32'sh000000A3;
      5'd23:   v = 32'sh00000051;
      default: v = 32'sh00000000;
    endcase
    return v;
  endfunction

endpackage

FILE: rtl/ppi_cordic.sv
// iterative rotation-mode cordic giving cos and sin of a binary angle in q2.30
module ppi_cordic (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [31:0]        angle,    // unit 2pi/2^32
  output logic               busy,
  output logic signed [31:0] cos_q30,
  output logic signed [31:0] sin_q30
);

  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } quad_t;

  logic                            busy_r;
  logic [ppi_pkg::ITER_W-1:0]      iter_r;
  quad_t                           quad_r;
  logic signed [31:0]              x_r, y_r, z_r;
  logic [31:0]                     quad_sum;
  quad_t                           quad_nxt;
  logic signed [31:0]              z_start;
  logic signed [31:0]              x_sh, y_sh, atan_v;
  logic                            last_iter;

  // fold the angle into the quadrant around zero
  assign quad_sum = angle + 32'h2000_0000;
  assign quad_nxt = quad_t'(quad_sum[31:30]);
  assign z_start  = signed'(angle - {quad_sum[31:30], 30'd0});

  // one micro-rotation per cycle
  assign x_sh      = x_r >>> iter_r;
  assign y_sh      = y_r >>> iter_r;
  assign atan_v    = ppi_pkg::atan_at(ppi_pkg::ATAN_IDX_W'(iter_r));
  assign last_iter = (iter_r == ppi_pkg::ITER_W'(ppi_pkg::CORDIC_STEPS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      iter_r <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      iter_r <= '0;
    end else if (busy_r) begin
      busy_r <= !last_iter;
      iter_r <= iter_r + 1'b1;
    end
  end

  // rotation datapath
  always_ff @(posedge clk) begin
    if (start) begin
      x_r    <= ppi_pkg::CORDIC_GAIN;
      y_r    <= '0;
      z_r    <= z_start;
      quad_r <= quad_nxt;
    end else if (busy_r) begin
      if (!z_r[31]) begin
        x_r <= x_r - y_sh;
        y_r <= y_r + x_sh;
        z_r <= z_r - atan_v;
      end else begin
        x_r <= x_r + y_sh;
        y_r <= y_r - x_sh;
        z_r <= z_r + atan_v;
      end
    end
  end

  // undo the quadrant fold
  always_comb begin
    case (quad_r)
      QUAD_0: begin
        cos_q30 = x_r;
        sin_q30 = y_r;
      end
      QUAD_1: begin
        cos_q30 = -y_r;
        sin_q30 = x_r;
      end
      QUAD_2: begin
        cos_q30 = -x_r;
        sin_q30 = -y_r;
      end
      default: begin
        cos_q30 = y_r;
        sin_q30 = -x_r;
      end
    endcase
  end

  assign busy = busy_r;

`ifndef SYNTHESIS
  // a start always launches a full run
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> busy_r && (iter_r == '0))
    else $error("cordic did not start its run");
`endif

endmodule

FILE: rtl/ppi_datapath.sv
// pose state, configuration registers, shared multiplier and result register
module ppi_datapath (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ppi_pkg::cmd_t        cmd,
  output ppi_pkg::sts_t        sts,
  // captured input beat
  input  logic [1:0]           in_op,
  input  logic [7:0]           in_target_id,
  input  logic [2:0]           in_mode,
  input  logic signed [15:0]   in_vel_forward,
  input  logic signed [15:0]   in_vel_left,
  input  logic signed [15:0]   in_turn_rate,
  // configuration write
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_index,
  input  logic [31:0]          cfg_data,
  // result register
  input  logic                 out_tready,
  output logic                 out_tvalid,
  output logic                 out_pose_valid,
  output logic signed [31:0]   out_x,
  output logic signed [31:0]   out_y,
  output logic signed [31:0]   out_z,
  output logic signed [15:0]   out_quat_z,
  output logic signed [15:0]   out_quat_w
);

  // configuration
  logic [7:0]                        own_id_r;
  logic signed [31:0]                fly_height_r;
  logic [15:0]                       step_time_r;
  // pose and held velocity
  logic signed [31:0]                pos_x_r, pos_y_r, pos_z_r;
  logic [31:0]                       heading_r;
  logic signed [ppi_pkg::VEL_W-1:0]  vel_east_r, vel_north_r;
  logic signed [ppi_pkg::RATE_W-1:0] rate_r;
  ppi_pkg::mode_t                    ctrl_mode_r;
  // captured beat
  ppi_pkg::op_t                      op_r;
  logic [7:0]                        tid_r;
  ppi_pkg::mode_t                    md_r;
  logic signed [15:0]                fwd_r, left_r, rate_in_r;
  // arithmetic
  logic signed [63:0]                prod_r, acc_r;
  logic signed [31:0]                mul_a, mul_b;
  logic signed [63:0]                prod_nxt;
  logic signed [63:0]                acc_rnd, pos_rnd, head_rnd;
  logic signed [33:0]                vel_full;
  logic signed [ppi_pkg::VEL_W-1:0]  vel_sat_nxt;
  // result register
  logic                              out_valid_r;
  logic                              pose_valid_r;
  logic signed [31:0]                out_x_r, out_y_r, out_z_r;
  logic signed [15:0]                quat_z_r, quat_w_r;
  // trig
  logic [31:0]                       cordic_ang;
  logic                              cordic_busy;
  logic signed [31:0]                cos_q30, sin_q30;

  // round half up from q2.30 to q1.15 and saturate
  function automatic logic signed [15:0] to_q15(input logic signed [31:0] v);
    logic signed [32:0] s;
    logic signed [17:0] r;
    logic signed [15:0] q;
    s = 33'(v) + 33'sd16384;
    r = s[32:15];
    if (r > 18'sd32767)       q = 16'sh7FFF;
    else if (r < -18'sd32768) q = 16'sh8000;
    else                      q = r[15:0];
    return q;
  endfunction

  // trig unit
  assign cordic_ang = cmd.ang_double ? {heading_r[30:0], 1'b0} : heading_r;

  ppi_cordic u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cmd.cordic_start),
    .angle   (cordic_ang),
    .busy    (cordic_busy),
    .cos_q30 (cos_q30),
    .sin_q30 (sin_q30)
  );

  // multiplier operand select
  always_comb begin
    case (cmd.mul_sel)
      ppi_pkg::MUL_FC: begin
        mul_a = 32'(fwd_r);
        mul_b = cos_q30;
      end
      ppi_pkg::MUL_LS: begin
        mul_a = 32'(left_r);
        mul_b = sin_q30;
      end
      ppi_pkg::MUL_FS: begin
        mul_a = 32'(fwd_r);
        mul_b = sin_q30;
      end
      ppi_pkg::MUL_LC: begin
        mul_a = 32'(left_r);
        mul_b = cos_q30;
      end
      ppi_pkg::MUL_EDT: begin
        mul_a = 32'(vel_east_r);
        mul_b = signed'(32'(step_time_r));
      end
      ppi_pkg::MUL_NDT: begin
        mul_a = 32'(vel_north_r);
        mul_b = signed'(32'(step_time_r));
      end
      ppi_pkg::MUL_RDT: begin
        mul_a = 32'(rate_r);
        mul_b = signed'(32'(step_time_r));
      end
      ppi_pkg::MUL_PK: begin
        mul_a = prod_r[31:0];
        mul_b = ppi_pkg::FOUR_OVER_PI_Q30;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_nxt = mul_a * mul_b;

  // rounding of products and sums
  assign acc_rnd  = acc_r + 64'sd536870912;
  assign vel_full = acc_rnd[63:30];
  assign pos_rnd  = prod_r + 64'sd2048;
  assign head_rnd = prod_r + 64'sd536870912;

  always_comb begin
    if (vel_full > 34'(ppi_pkg::VEL_MAX))      vel_sat_nxt = ppi_pkg::VEL_MAX;
    else if (vel_full < 34'(ppi_pkg::VEL_MIN)) vel_sat_nxt = ppi_pkg::VEL_MIN;
    else                                       vel_sat_nxt = vel_full[ppi_pkg::VEL_W-1:0];
  end

  // captured beat, products and result payload
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r      <= ppi_pkg::op_t'(in_op);
      tid_r     <= in_target_id;
      md_r      <= ppi_pkg::mode_t'(in_mode);
      fwd_r     <= in_vel_forward;
      left_r    <= in_vel_left;
      rate_in_r <= in_turn_rate;
    end
    prod_r <= prod_nxt;
    case (cmd.acc_op)
      ppi_pkg::ACC_LOAD: acc_r <= prod_r;
      ppi_pkg::ACC_ADD:  acc_r <= acc_r + prod_r;
      ppi_pkg::ACC_SUB:  acc_r <= acc_r - prod_r;
      default:           acc_r <= acc_r;
    endcase
    if (cmd.out_load) begin
      if (cmd.out_null) begin
        pose_valid_r <= 1'b0;
        out_x_r      <= '0;
        out_y_r      <= '0;
        out_z_r      <= '0;
        quat_z_r     <= '0;
        quat_w_r     <= '0;
      end else begin
        pose_valid_r <= 1'b1;
        out_x_r      <= pos_x_r;
        out_y_r      <= pos_y_r;
        out_z_r      <= pos_z_r;
        quat_z_r     <= to_q15(sin_q30);
        quat_w_r     <= to_q15(cos_q30);
      end
    end
  end

  // configuration, pose state and result handshake
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_id_r     <= ppi_pkg::OWN_ID_RST;
      fly_height_r <= ppi_pkg::FLY_HEIGHT_RST;
      step_time_r  <= ppi_pkg::STEP_TIME_RST;
      pos_x_r      <= ppi_pkg::START_X_RST;
      pos_y_r      <= ppi_pkg::START_Y_RST;
      pos_z_r      <= ppi_pkg::START_Z_RST;
      heading_r    <= ppi_pkg::START_HEAD_RST;
      vel_east_r   <= '0;
      vel_north_r  <= '0;
      rate_r       <= '0;
      ctrl_mode_r  <= ppi_pkg::MODE_INIT;
      out_valid_r  <= 1'b0;
    end else begin
      if (cmd.set_mode) begin
        ctrl_mode_r <= md_r;
      end
      // state updates of the rotate and integrate sequences
      case (cmd.wr)
        ppi_pkg::WR_EAST: vel_east_r <= vel_sat_nxt;
        ppi_pkg::WR_NORTH: begin
          vel_north_r <= vel_sat_nxt;
          rate_r      <= rate_in_r;
        end
        ppi_pkg::WR_X:    pos_x_r   <= pos_x_r + pos_rnd[43:12];
        ppi_pkg::WR_Y:    pos_y_r   <= pos_y_r + pos_rnd[43:12];
        ppi_pkg::WR_HEAD: heading_r <= heading_r + head_rnd[61:30];
        default: ;
      endcase
      case (cmd.z_sel)
        ppi_pkg::Z_FLY:  pos_z_r <= fly_height_r;
        ppi_pkg::Z_LAND: pos_z_r <= ppi_pkg::LAND_Z;
        default: ;
      endcase
      // register writes, start values also preset the pose
      if (cfg_we) begin
        case (ppi_pkg::cfg_idx_t'(cfg_index))
          ppi_pkg::CFG_OWN_ID:     own_id_r     <= cfg_data[7:0];
          ppi_pkg::CFG_START_X:    pos_x_r      <= signed'(cfg_data);
          ppi_pkg::CFG_START_Y:    pos_y_r      <= signed'(cfg_data);
          ppi_pkg::CFG_START_Z:    pos_z_r      <= signed'(cfg_data);
          ppi_pkg::CFG_START_HEAD: heading_r    <= cfg_data;
          ppi_pkg::CFG_FLY_HEIGHT: fly_height_r <= signed'(cfg_data);
          ppi_pkg::CFG_STEP_TIME:  step_time_r  <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // status to the controller
  always_comb begin
    sts.op          = op_r;
    sts.mode_hit    = (tid_r == own_id_r) || (tid_r == ppi_pkg::BROADCAST_ID);
    sts.ctrl_mode   = ctrl_mode_r;
    sts.cordic_busy = cordic_busy;
    sts.out_free    = !out_valid_r || out_tready;
  end

  assign out_tvalid     = out_valid_r;
  assign out_pose_valid = pose_valid_r;
  assign out_x          = out_x_r;
  assign out_y          = out_y_r;
  assign out_z          = out_z_r;
  assign out_quat_z     = quat_z_r;
  assign out_quat_w     = quat_w_r;

endmodule

FILE: rtl/ppi_ctrl.sv
// sequencer for mode, velocity and tick beats
module ppi_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  ppi_pkg::sts_t sts,
  output ppi_pkg::cmd_t cmd
);

  typedef enum logic [4:0] {
    S_IDLE,
    S_DISPATCH,
    S_VWAIT,
    S_V0,
    S_V1,
    S_V2,
    S_V3,
    S_V4,
    S_V5,
    S_T0,
    S_T1,
    S_T2,
    S_T3,
    S_T4,
    S_TSTART,
    S_TWAIT,
    S_EMIT
  } state_t;

  state_t state_r, state_nxt;

  // next state and command decode
  always_comb begin
    state_nxt        = state_r;
    in_tready        = 1'b0;
    cmd.capture      = 1'b0;
    cmd.set_mode     = 1'b0;
    cmd.cordic_start = 1'b0;
    cmd.ang_double   = 1'b0;
    cmd.mul_sel      = ppi_pkg::MUL_FC;
    cmd.acc_op       = ppi_pkg::ACC_NONE;
    cmd.wr           = ppi_pkg::WR_NONE;
    cmd.z_sel        = ppi_pkg::Z_KEEP;
    cmd.out_load     = 1'b0;
    cmd.out_null     = (sts.ctrl_mode == ppi_pkg::MODE_OTHER);
    case (state_r)
      S_IDLE: begin
        in_tready   = 1'b1;
        cmd.capture = in_tvalid;
        if (in_tvalid) state_nxt = S_DISPATCH;
      end
      S_DISPATCH: begin
        case (sts.op)
          ppi_pkg::OP_MODE: begin
            cmd.set_mode = sts.mode_hit;
            state_nxt    = S_IDLE;
          end
          ppi_pkg::OP_VEL: begin
            cmd.cordic_start = 1'b1;
            cmd.ang_double   = 1'b1;
            state_nxt        = S_VWAIT;
          end
          ppi_pkg::OP_TICK: begin
            case (sts.ctrl_mode)
              ppi_pkg::MODE_OTHER: state_nxt = S_EMIT;
              ppi_pkg::MODE_POS, ppi_pkg::MODE_VEL_BODY,
              ppi_pkg::MODE_VEL_WORLD: state_nxt = S_T0;
              ppi_pkg::MODE_TAKEOFF: begin
                cmd.z_sel        = ppi_pkg::Z_FLY;
                cmd.cordic_start = 1'b1;
                state_nxt        = S_TWAIT;
              end
              ppi_pkg::MODE_LAND: begin
                cmd.z_sel        = ppi_pkg::Z_LAND;
                cmd.cordic_start = 1'b1;
                state_nxt        = S_TWAIT;
              end
              default: begin
                cmd.cordic_start = 1'b1;
                state_nxt        = S_TWAIT;
              end
            endcase
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      // body to world rotation
      S_VWAIT: begin
        cmd.mul_sel = ppi_pkg::MUL_FC;
        if (!sts.cordic_busy) state_nxt = S_V0;
      end
      S_V0: begin
        cmd.mul_sel = ppi_pkg::MUL_FC;
        state_nxt   = S_V1;
      end
      S_V1: begin
        cmd.mul_sel = ppi_pkg::MUL_LS;
        cmd.acc_op  = ppi_pkg::ACC_LOAD;
        state_nxt   = S_V2;
      end
      S_V2: begin
        cmd.mul_sel = ppi_pkg::MUL_FS;
        cmd.acc_op  = ppi_pkg::ACC_SUB;
        state_nxt   = S_V3;
      end
      S_V3: begin
        cmd.mul_sel = ppi_pkg::MUL_LC;
        cmd.acc_op  = ppi_pkg::ACC_LOAD;
        cmd.wr      = ppi_pkg::WR_EAST;
        state_nxt   = S_V4;
      end
      S_V4: begin
        cmd.acc_op = ppi_pkg::ACC_ADD;
        state_nxt  = S_V5;
      end
      S_V5: begin
        cmd.wr    = ppi_pkg::WR_NORTH;
        state_nxt = S_IDLE;
      end
      // one integration step
      S_T0: begin
        cmd.mul_sel = ppi_pkg::MUL_EDT;
        state_nxt   = S_T1;
      end
      S_T1: begin
        cmd.mul_sel = ppi_pkg::MUL_NDT;
        cmd.wr      = ppi_pkg::WR_X;
        state_nxt   = S_T2;
      end
      S_T2: begin
        cmd.mul_sel = ppi_pkg::MUL_RDT;
        cmd.wr      = ppi_pkg::WR_Y;
        state_nxt   = S_T3;
      end
      S_T3: begin
        cmd.mul_sel = ppi_pkg::MUL_PK;
        state_nxt   = S_T4;
      end
      S_T4: begin
        cmd.wr    = ppi_pkg::WR_HEAD;
        cmd.z_sel = ppi_pkg::Z_FLY;
        state_nxt = S_TSTART;
      end
      S_TSTART: begin
        cmd.cordic_start = 1'b1;
        state_nxt        = S_TWAIT;
      end
      S_TWAIT: begin
        if (!sts.cordic_busy) state_nxt = S_EMIT;
      end
      // hand the pose beat to the result register
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef SYNTHESIS
  // the result register is never overwritten while it still holds a beat
  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> sts.out_free)
    else $error("result loaded into a full output register");

  // the trig unit is only started when idle
  a_cordic_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cordic_start |-> !sts.cordic_busy)
    else $error("trig unit restarted while busy");

  // an accepted beat is always decoded in the next cycle
  a_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == S_DISPATCH))
    else $error("accepted beat not dispatched");
`endif

endmodule

FILE: rtl/planar_pose_integrator.sv
// top level of the planar pose integrator
//
// dead reckoning of a planar vehicle flying at a fixed altitude.
// in_*  : stream of command beats. tuser selects the operation (mode command,
//         velocity command or tick); tdata carries target id, mode and the
//         body velocities and turn rate.
// out_* : one pose beat per tick: x, y, z in q16.16 and the yaw quaternion
//         (z, w) in q1.15; tuser is the pose-valid flag.
// cfg_* : register writes by index, taken in every cycle; the user must write
//         them only while the block is idle, which the block does not enforce.
// one beat is worked at a time. velocity commands and ticks, but for ticks in
// the unknown mode, run the 16 iterations of the shared cordic, and the
// rotation and integration steps go through the single multiplier in turn.
// the pose beat sits in an output register, so the next input beat is taken
// while it waits; a stalled receiver only holds the block when the next pose
// is ready to be loaded.
// synchronous reset loads the reset register values, the start pose, zero
// velocity and init mode, and empties the output register.
module planar_pose_integrator (
  input  logic         clk,
  input  logic         rst_n,
  // input stream
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [63:0]  in_tdata,   // target_id[7:0], mode[10:8], vel_forward[26:11],
                                   // vel_left[42:27], turn_rate[58:43], zero[63:59]
  input  logic [1:0]   in_tuser,   // operation[1:0]
  // result stream
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata,  // out_x[31:0], out_y[63:32], out_z[95:64],
                                   // quat_z[111:96], quat_w[127:112]
  output logic         out_tuser,  // pose_valid
  // configuration
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  ppi_pkg::cmd_t      cmd;
  ppi_pkg::sts_t      sts;
  logic               pose_valid;
  logic signed [31:0] pos_x, pos_y, pos_z;
  logic signed [15:0] quat_z, quat_w;

  assign cfg_ready = 1'b1;

  ppi_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ppi_datapath u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_op          (in_tuser),
    .in_target_id   (in_tdata[7:0]),
    .in_mode        (in_tdata[10:8]),
    .in_vel_forward (signed'(in_tdata[26:11])),
    .in_vel_left    (signed'(in_tdata[42:27])),
    .in_turn_rate   (signed'(in_tdata[58:43])),
    .cfg_we         (cfg_valid && cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .out_tready     (out_tready),
    .out_tvalid     (out_tvalid),
    .out_pose_valid (pose_valid),
    .out_x          (pos_x),
    .out_y          (pos_y),
    .out_z          (pos_z),
    .out_quat_z     (quat_z),
    .out_quat_w     (quat_w)
  );

  // result beat packing
  assign out_tdata = {quat_w, quat_z, pos_z, pos_y, pos_x};
  assign out_tuser = pose_valid;

endmodule

FILE: tb/planar_pose_integrator_tb.sv
// testbench of the planar pose integrator: directed table, random phases, pose prediction
`timescale 1ns / 1ps

module planar_pose_integrator_tb;

  // spare codes the package leaves out, the broadcast id and run limits
  localparam logic [1:0] OP_SPARE    = 2'd3;
  localparam logic [2:0] CFG_SPARE   = 3'd7;
  localparam logic [7:0] BCAST_ID    = 8'd99;
  localparam int         CYCLE_LIMIT = 500000;
  localparam int         HOLD_CYCLES = 600;

  // one input beat and one pose beat
  typedef struct packed {
    logic [1:0]         op;
    logic [7:0]         tid;
    logic [2:0]         mode;
    logic signed [15:0] fwd;
    logic signed [15:0] left;
    logic signed [15:0] rate;
  } beat_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [15:0] qz;
    logic [15:0] qw;
  } pose_t;

  typedef struct {
    beat_t beat;
    bit    typed;
    pose_t want;
  } plan_row_t;

  logic         clk = 1'b0;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [63:0]  in_tdata;
  logic [1:0]   in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [127:0] out_tdata;
  logic         out_tuser;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [2:0]   cfg_index;
  logic [31:0]  cfg_data;

  planar_pose_integrator uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  // predicted registers and pose state
  logic [7:0]         cfg_own_id;
  logic [31:0]        cfg_fly_height;
  logic [15:0]        cfg_step_time;
  logic [31:0]        pose_x, pose_y, pose_z, yaw_angle;
  logic signed [17:0] v_east, v_north;
  logic signed [15:0] yaw_rate;
  ppi_pkg::mode_t     nav_mode;

  pose_t pending_poses[$];
  int    errors = 0;
  int    cycle_count = 0;
  int    burst_left = 0;
  bit    steady = 1'b0;
  int    hold_reqs = 0;

  // arctangent of 2^-i, unit 2pi/2^32
  function automatic longint atan_step(input int i);
    case (i)
      0:  return 64'h20000000;
      1:  return 64'h12E4051E;
      2:  return 64'h09FB385B;
      3:  return 64'h051111D4;
      4:  return 64'h028B0D43;
      5:  return 64'h0145D7E1;
      6:  return 64'h00A2F61E;
      7:  return 64'h00517C55;
      8:  return 64'h0028BE53;
      9:  return 64'h00145F2F;
      10: return 64'h000A2F98;
      11: return 64'h000517CC;
      12: return 64'h00028BE6;
      13: return 64'h000145F3;
      14: return 64'h0000A2FA;
      15: return 64'h0000517D;
      16: return 64'h000028BE;
      17: return 64'h0000145F;
      18: return 64'h00000A30;
      19: return 64'h00000518;
      20: return 64'h0000028C;
      21: return 64'h00000146;
      22: return 64'h000000A3;
      23: return 64'h00000051;
      default: return 64'h0;
    endcase
  endfunction

  // rotation-mode cordic, q2.30 cos and sin of a binary angle (unit 2pi/2^32)
  function automatic void cordic_sincos(input logic [31:0] ang, output longint c,
                                        output longint s);
    logic [31:0] quad;
    logic [31:0] rest;
    longint      z, x, y, t;
    quad = ((ang + 32'h20000000) >> 30) & 32'd3;
    rest = ang - (quad << 30);
    z = $signed(rest);
    x = 64'sd652032874;
    y = 0;
    for (int i = 0; i < ppi_pkg::CORDIC_STEPS && i < 24; i++) begin
      if (z >= 0) begin
        t = x - (y >>> i);
        y = y + (x >>> i);
        x = t;
        z = z - atan_step(i);
      end else begin
        t = x + (y >>> i);
        y = y - (x >>> i);
        x = t;
        z = z + atan_step(i);
      end
    end
    case (quad[1:0])
      2'd0: begin c = x;  s = y;  end
      2'd1: begin c = -y; s = x;  end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endfunction

  function automatic longint clamp(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // q2.30 to q1.15, rounded half up and saturated
  function automatic logic [15:0] to_q15(input longint v);
    longint r;
    r = clamp((v + 64'sd16384) >>> 15, -32768, 32767);
    return r[15:0];
  endfunction

  // advances the pose state by one accepted beat; returns 1 with the pose it emits
  function automatic bit dead_reckon(input beat_t b, output pose_t p);
    longint c, s, dt, f, l, e, n, turn, dx, dy, dh;
    p = '0;
    dt = cfg_step_time;
    case (b.op)
      ppi_pkg::OP_MODE: begin
        if (b.tid == cfg_own_id || b.tid == BCAST_ID)
          nav_mode = ppi_pkg::mode_t'(b.mode);
        return 1'b0;
      end
      ppi_pkg::OP_VEL: begin
        // body to world rotation by the yaw at arrival
        f = b.fwd;
        l = b.left;
        cordic_sincos(yaw_angle << 1, c, s);
        e = clamp((f * c - l * s + 64'sd536870912) >>> 30, -131072, 131071);
        n = clamp((f * s + l * c + 64'sd536870912) >>> 30, -131072, 131071);
        v_east = e[17:0];
        v_north = n[17:0];
        yaw_rate = b.rate;
        return 1'b0;
      end
      ppi_pkg::OP_TICK: ;
      default: return 1'b0;
    endcase
    // unknown mode gives a null pose and keeps the state
    if (nav_mode == ppi_pkg::MODE_OTHER)
      return 1'b1;
    if (nav_mode >= ppi_pkg::MODE_POS && nav_mode <= ppi_pkg::MODE_VEL_WORLD) begin
      turn = yaw_rate * dt;
      dx = (v_east * dt + 2048) >>> 12;
      dy = (v_north * dt + 2048) >>> 12;
      dh = (turn * 64'sd1367130551 + 64'sd536870912) >>> 30;
      pose_x = pose_x + dx[31:0];
      pose_y = pose_y + dy[31:0];
      pose_z = cfg_fly_height;
      yaw_angle = yaw_angle + dh[31:0];
    end else if (nav_mode == ppi_pkg::MODE_TAKEOFF) begin
      pose_z = cfg_fly_height;
    end else if (nav_mode == ppi_pkg::MODE_LAND) begin
      pose_z = 32'd3277;
    end
    cordic_sincos(yaw_angle, c, s);
    p.valid = 1'b1;
    p.x = pose_x;
    p.y = pose_y;
    p.z = pose_z;
    p.qz = to_q15(s);
    p.qw = to_q15(c);
    return 1'b1;
  endfunction

  function automatic plan_row_t row(input logic [1:0] op, input logic [7:0] tid,
                                    input logic [2:0] md, input int f, input int l,
                                    input int r, input bit typed, input logic v,
                                    input logic [31:0] z);
    plan_row_t pr;
    pr.beat.op = op;
    pr.beat.tid = tid;
    pr.beat.mode = md;
    pr.beat.fwd = 16'(f);
    pr.beat.left = 16'(l);
    pr.beat.rate = 16'(r);
    pr.typed = typed;
    pr.want = '0;
    pr.want.valid = v;
    pr.want.z = z;
    return pr;
  endfunction

  // velocity field with a bias towards both extremes
  function automatic logic [15:0] pick_vel();
    int k;
    k = $urandom_range(0, 7);
    if (k == 0) return 16'h8000;
    if (k == 1) return 16'h7FFF;
    return 16'($urandom);
  endfunction

  // offers one beat in bursts with random gaps, predicts on acceptance
  task automatic send_beat(input beat_t b, input bit typed, input pose_t want);
    pose_t p;
    int    gap;
    if (burst_left == 0) begin
      gap = steady ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser <= b.op;
    in_tdata <= {5'd0, b.rate, b.left, b.fwd, b.mode, b.tid};
    do @(posedge clk); while (!in_tready);
    if (dead_reckon(b, p)) begin
      if (typed) begin
        p.valid = want.valid;
        p.x = want.x;
        p.y = want.y;
        p.z = want.z;
      end
      pending_poses.push_back(p);
    end
    @(negedge clk);
  endtask

  // stops offering, waits for every pose, then lets the block go quiet
  task automatic settle(input int extra);
    in_tvalid <= 1'b0;
    do @(negedge clk); while (pending_poses.size() != 0);
    repeat (extra) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    // start registers also preset the pose
    case (idx)
      ppi_pkg::CFG_OWN_ID:     cfg_own_id = val[7:0];
      ppi_pkg::CFG_START_X:    pose_x = val;
      ppi_pkg::CFG_START_Y:    pose_y = val;
      ppi_pkg::CFG_START_Z:    pose_z = val;
      ppi_pkg::CFG_START_HEAD: yaw_angle = val;
      ppi_pkg::CFG_FLY_HEIGHT: cfg_fly_height = val;
      ppi_pkg::CFG_STEP_TIME:  cfg_step_time = val[15:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic program_regs(input logic [7:0] own, input logic [31:0] sx,
                              input logic [31:0] sy, input logic [31:0] sz,
                              input logic [31:0] sh, input logic [31:0] fh,
                              input logic [15:0] st);
    logic [31:0] junk;
    junk = $urandom;
    write_reg(ppi_pkg::CFG_OWN_ID, {junk[31:8], own});
    write_reg(ppi_pkg::CFG_START_X, sx);
    write_reg(ppi_pkg::CFG_START_Y, sy);
    write_reg(ppi_pkg::CFG_START_Z, sz);
    write_reg(ppi_pkg::CFG_START_HEAD, sh);
    write_reg(ppi_pkg::CFG_FLY_HEIGHT, fh);
    write_reg(ppi_pkg::CFG_STEP_TIME, {junk[31:16], st});
    write_reg(CFG_SPARE, $urandom);
    cfg_valid <= 1'b0;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endtask

  // pose beat monitor
  always @(posedge clk) begin
    pose_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tuser, out_tdata[31:0], out_tdata[63:32], out_tdata[95:64],
             out_tdata[111:96], out_tdata[127:112]};
      if (pending_poses.size() == 0) begin
        $error("pose beat with none expected: %0h", got);
        errors++;
      end else begin
        want = pending_poses.pop_front();
        check_field("pose_valid", 32'(want.valid), 32'(got.valid));
        check_field("out_x", want.x, got.x);
        check_field("out_y", want.y, got.y);
        check_field("out_z", want.z, got.z);
        check_field("quat_z", 32'(want.qz), 32'(got.qz));
        check_field("quat_w", 32'(want.qw), 32'(got.qw));
      end
    end
  end

  // run length guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // receiver: changing stall patterns plus requested long hold-offs
  initial begin
    int holds_done, hold_left, pat_kind, pat_left;
    holds_done = 0;
    hold_left = 0;
    pat_kind = 0;
    pat_left = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_reqs != holds_done) begin
        holds_done++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        if (pat_left == 0) begin
          pat_kind = $urandom_range(0, 3);
          pat_left = $urandom_range(20, 200);
        end
        pat_left--;
        case (pat_kind)
          0: out_tready <= 1'b1;
          1: out_tready <= 1'($urandom_range(0, 1));
          2: out_tready <= ($urandom_range(0, 3) == 0);
          default: out_tready <= ((pat_left % 8) < 5);
        endcase
      end
    end
  end

  // stimulus
  initial begin
    plan_row_t   plan[$];
    beat_t       b;
    pose_t       no_pose;
    int          n, counted, sel;
    logic [31:0] r1, r2, r3, r4, r5;

    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    no_pose = '0;

    // state after reset
    cfg_own_id = 8'd0;
    cfg_fly_height = 32'd6554;
    cfg_step_time = 16'd655;
    pose_x = '0;
    pose_y = '0;
    pose_z = 32'd655;
    yaw_angle = '0;
    v_east = '0;
    v_north = '0;
    yaw_rate = '0;
    nav_mode = ppi_pkg::MODE_INIT;

    // directed table, own id 0 after reset
    plan.push_back(row(ppi_pkg::OP_TICK, 8'd0, ppi_pkg::MODE_INIT, 0, 0, 0,
                       1'b1, 1'b1, 32'd655));
    plan.push_back(row(OP_SPARE, 8'hFF, ppi_pkg::MODE_OTHER, -1, -1, -1,
                       1'b0, 1'b0, 32'd0));
    plan.push_back(row(ppi_pkg::OP_MODE, 8'd5, ppi_pkg::MODE_POS, 0, 0, 0,
                       1'b0, 1'b0, 32'd0));
    plan.push_back(row(ppi_pkg::OP_TICK, 8'd0, ppi_pkg::MODE_INIT, 0, 0, 0,
                       1'b1, 1'b1, 32'd655));
    plan.push_back(row(ppi_pkg::OP_MODE, BCAST_ID, ppi_pkg::MODE_HOLD, 0, 0, 0,
                       1'b0, 1'b0, 32'd0));
    plan.push_back(row(ppi_pkg::OP_TICK, 8'd0, ppi_pkg::MODE_INIT, 0, 0, 0,
                       1'b1, 1'b1, 32'd655));
    plan.push_back(row(ppi_pkg::OP_VEL, 8'd0, ppi_pkg::MODE_INIT, 32767, -32768, 32767,
                       1'b0, 1'b0, 32'd0));
    plan.push_back(row(ppi_pkg::OP_TICK, 8'd0, ppi_pkg::MODE_INIT, 0, 0, 0,
                       1'b1, 1'b1, 32'd655));
    plan.push_back(row(ppi_pkg::OP_MODE, 8'd0, ppi_pkg::MODE_TAKEOFF, 0, 0, 0,
                       1'b0, 1'b0, 32'd0));
    plan.push_back(row(ppi_pkg::OP_TICK, 8'd0, ppi_pkg::MODE_INIT, 0, 0, 0,
                       1'b1, 1'b1, 32'd6554));
    plan.push_back(row(ppi_pkg::OP_MODE, BCAST_ID, ppi_pkg::MODE_LAND, 0, 0, 0,
                       1'b0, 1'b0, 32'd0));
    plan.push_back(row(ppi_pkg::OP_TICK, 8'd0, ppi_pkg::MODE_INIT, 0, 0, 0,
                       1'b1, 1'b1, 32'd3277));
    plan.push_back(row(ppi_pkg::OP_MODE, 8'd0, ppi_pkg::MODE_VEL_BODY, 0, 0, 0,
                       1'b0, 1'b0, 32'd0));
    plan.push_back(row(ppi_pkg::OP_TICK, 8'd0, ppi_pkg::MODE_INIT, 0, 0, 0,
                       1'b0, 1'b0, 32'd0));
    plan.push_back(row(ppi_pkg::OP_VEL, 8'd0, ppi_pkg::MODE_INIT, -32768, 32767, -32768,
                       1'b0, 1'b0, 32'd0));
    plan.push_back(row(ppi_pkg::OP_TICK, 8'd0, ppi_pkg::MODE_INIT, 0, 0, 0,
                       1'b0, 1'b0, 32'd0));
    plan.push_back(row(ppi_pkg::OP_MODE, BCAST_ID, ppi_pkg::MODE_POS, 0, 0, 0,
                       1'b0, 1'b0, 32'd0));
    plan.push_back(row(ppi_pkg::OP_TICK, 8'd0, ppi_pkg::MODE_INIT, 0, 0, 0,
                       1'b0, 1'b0, 32'd0));
    plan.push_back(row(ppi_pkg::OP_MODE, 8'd0, ppi_pkg::MODE_VEL_WORLD, 0, 0, 0,
                       1'b0, 1'b0, 32'd0));
    plan.push_back(row(ppi_pkg::OP_VEL, 8'd0, ppi_pkg::MODE_INIT, 0, 0, 0,
                       1'b0, 1'b0, 32'd0));
    plan.push_back(row(ppi_pkg::OP_TICK, 8'd0, ppi_pkg::MODE_INIT, 0, 0, 0,
                       1'b0, 1'b0, 32'd0));
    plan.push_back(row(ppi_pkg::OP_MODE, 8'd0, ppi_pkg::MODE_OTHER, 0, 0, 0,
                       1'b0, 1'b0, 32'd0));
    plan.push_back(row(ppi_pkg::OP_TICK, 8'd0, ppi_pkg::MODE_INIT, 0, 0, 0,
                       1'b1, 1'b0, 32'd0));
    plan.push_back(row(ppi_pkg::OP_MODE, 8'd0, ppi_pkg::MODE_INIT, 0, 0, 0,
                       1'b0, 1'b0, 32'd0));
    plan.push_back(row(ppi_pkg::OP_TICK, 8'd0, ppi_pkg::MODE_INIT, 0, 0, 0,
                       1'b0, 1'b0, 32'd0));

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (plan[i])
      send_beat(plan[i].beat, plan[i].typed, plan[i].want);

    // random phases, each under its own register setting
    for (int ph = 1; ph <= 8; ph++) begin
      settle(48);
      r1 = $urandom;
      r2 = $urandom;
      r3 = $urandom;
      r4 = $urandom;
      r5 = $urandom;
      case (ph)
        1: program_regs(8'hFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'hFFFFFFFF,
                        32'h7FFFFFFF, 16'hFFFF);
        2: program_regs(8'h00, 32'h80000000, 32'h80000000, 32'h80000000, 32'h00000000,
                        32'h80000000, 16'd1);
        3: program_regs(BCAST_ID, r1, r2, r3, r4, r5, 16'd0);
        default: program_regs(8'($urandom), r1, r2, r3, r4, r5,
                              16'($urandom_range(1, 65535)));
      endcase
      steady = (ph % 3 == 0);
      n = 0;
      counted = 0;
      while (counted < 155) begin
        b.op = ppi_pkg::OP_TICK;
        b.tid = 8'($urandom);
        b.mode = 3'($urandom);
        b.fwd = 16'($urandom);
        b.left = 16'($urandom);
        b.rate = 16'($urandom);
        sel = $urandom_range(0, 99);
        if (sel < 10) begin
          // addressed mode command, mostly a motion mode
          b.op = ppi_pkg::OP_MODE;
          b.tid = $urandom_range(0, 1) ? cfg_own_id : BCAST_ID;
          if ($urandom_range(0, 2) != 0)
            b.mode = 3'($urandom_range(ppi_pkg::MODE_POS, ppi_pkg::MODE_VEL_WORLD));
          counted++;
        end else if (sel < 25) begin
          b.op = ppi_pkg::OP_VEL;
          b.fwd = pick_vel();
          b.left = pick_vel();
          b.rate = pick_vel();
          counted++;
        end else if (sel < 31) begin
          // noise: spare operation or a command for another agent
          if ($urandom_range(0, 1)) begin
            b.op = OP_SPARE;
          end else begin
            b.op = ppi_pkg::OP_MODE;
            while (b.tid == cfg_own_id || b.tid == BCAST_ID)
              b.tid = 8'($urandom);
          end
        end else begin
          counted++;
        end
        send_beat(b, 1'b0, no_pose);
        n++;
        // long receiver hold-off while beats keep coming
        if ((ph == 2 || ph == 6) && n == 60)
          hold_reqs++;
        // sender waits for every pose before going on
        if ((ph == 4 || ph == 7) && n == 100)
          settle(0);
      end
    end

    settle(64);
    if (errors == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/ppi_pkg.sv
rtl/ppi_cordic.sv
rtl/ppi_datapath.sv
rtl/ppi_ctrl.sv
rtl/planar_pose_integrator.sv
tb/planar_pose_integrator_tb.sv
